### hdl/bpa_pkg.sv
// Shared types and constants for the next-fit bitmap page allocator.
// Used by bpa_ctrl, bpa_dpath and bitmap_page_allocator_next_fit; depends on nothing.
package bpa_pkg;

   // Default sizing; WORD_BITS must be a power of two
   localparam int MAX_PAGES_DEF = 65536;
   localparam int WORD_BITS_DEF = 64;

   localparam int LIMIT_W = 17;
   localparam int START_W = 16;
   localparam int COUNT_W = 17;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clr_wr;     // write one all-used word of the clearing pass
      logic accept;     // latch a new request
      logic pass2;      // restart the scan at page 0, up to the old cursor
      logic scan_rd;    // read the bitmap word under the cursor
      logic scan_step;  // test one page and advance the cursor
      logic fail;       // restore the cursor, record a failed allocation
      logic rmw_rd;     // read the word to be updated
      logic rmw_wr;     // write back the updated word
      logic rsp_load;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic op_free;
      logic count_zero;
      logic range_empty;
      logic scan_done;
      logic hit;
      logic boundary;
      logic rmw_last;
   } sts_type;

endpackage

### hdl/bpa_dpath.sv
// Datapath of the page allocator: bitmap memory, scan cursor, run counter and
// range update logic. Driven by bpa_ctrl through bpa_pkg::cmd_type; uses bpa_pkg.
module bpa_dpath #(
   parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
   parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr,
   input  logic [bpa_pkg::LIMIT_W-1:0]  csr_value,
   input  logic                         req_op,
   input  logic [bpa_pkg::START_W-1:0]  req_start,
   input  logic [bpa_pkg::COUNT_W-1:0]  req_count,
   input  bpa_pkg::cmd_type             cmd,
   output bpa_pkg::sts_type             sts,
   output logic                         rsp_granted,
   output logic [bpa_pkg::START_W-1:0]  rsp_first
);

   localparam int BL        = $clog2(WORD_BITS);
   localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW        = $clog2(MAX_PAGES + 1) + 1;
   localparam int AW        = (PW > 18) ? PW : 18;
   localparam int CW        = bpa_pkg::COUNT_W;

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic [bpa_pkg::LIMIT_W-1:0] limit_ff;
   logic [AW-1:0]        cursor_ff, old_ff, end_ff, lo_ff, hi_ff;
   logic [CW-1:0]        run_ff, count_ff;
   logic                 op_ff, set_ff, granted_ff;
   logic [WAW-1:0]       wa_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic [bpa_pkg::START_W-1:0] first_ff;
   logic                 rsp_granted_ff;
   logic [bpa_pkg::START_W-1:0] rsp_first_ff;

   logic [AW-1:0]        max_c, limit_ext, limit_clamp, start_ext, free_hi_raw, free_hi;
   logic [AW-1:0]        cursor_nx, hit_lo, hi_m1;
   logic [CW:0]          run_inc;
   logic                 page_free, hit;
   logic [WORD_BITS-1:0] mask, wr_data;

   always_comb begin
      max_c       = AW'(MAX_PAGES);
      limit_ext   = AW'(limit_ff);
      limit_clamp = (limit_ext > max_c) ? max_c : limit_ext;
      start_ext   = AW'(req_start);
      free_hi_raw = start_ext + AW'(req_count);
      free_hi     = (free_hi_raw > max_c) ? max_c : free_hi_raw;
      cursor_nx   = cursor_ff + AW'(1);
      hit_lo      = cursor_nx - AW'(count_ff);
      hi_m1       = hi_ff - AW'(1);
      page_free   = !rdata_ff[cursor_ff[BL-1:0]];
      run_inc     = {1'b0, run_ff} + (CW+1)'(1);
      hit         = page_free && (run_inc == {1'b0, count_ff});
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = (((AW'(wa_ff) << BL) | AW'(b)) >= lo_ff)
                && (((AW'(wa_ff) << BL) | AW'(b)) < hi_ff);
      end
      wr_data = set_ff ? (rdata_ff | mask) : (rdata_ff & ~mask);
   end

   always_comb begin
      sts.clr_last    = (wa_ff == WAW'(MAP_WORDS - 1));
      sts.op_free     = (op_ff == bpa_pkg::OP_FREE);
      sts.count_zero  = (count_ff == '0);
      sts.range_empty = (lo_ff >= hi_ff);
      sts.scan_done   = (cursor_ff >= end_ff);
      sts.hit         = hit;
      sts.boundary    = &cursor_ff[BL-1:0];
      sts.rmw_last    = (wa_ff == hi_m1[BL+WAW-1:BL]);
   end

   // Bitmap memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[wa_ff] <= '1;
      end else if (cmd.rmw_wr) begin
         mem[wa_ff] <= wr_data;
      end
      if (cmd.scan_rd) begin
         rdata_ff <= mem[cursor_ff[BL+WAW-1:BL]];
      end else if (cmd.rmw_rd) begin
         rdata_ff <= mem[wa_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= '0;
         cursor_ff <= '0;
         wa_ff     <= '0;
      end else begin
         if (csr_wr) begin
            limit_ff <= csr_value;
         end
         if (cmd.clr_wr || cmd.rmw_wr) begin
            wa_ff <= wa_ff + WAW'(1);
         end
         if (cmd.accept) begin
            op_ff      <= req_op;
            count_ff   <= req_count;
            old_ff     <= cursor_ff;
            end_ff     <= limit_clamp;
            run_ff     <= '0;
            lo_ff      <= start_ext;
            hi_ff      <= free_hi;
            set_ff     <= 1'b0;
            wa_ff      <= start_ext[BL+WAW-1:BL];
            granted_ff <= (req_op == bpa_pkg::OP_FREE);
            first_ff   <= '0;
         end
         if (cmd.pass2) begin
            cursor_ff <= '0;
            end_ff    <= old_ff;
            run_ff    <= '0;
         end
         if (cmd.scan_step) begin
            cursor_ff <= cursor_nx;
            run_ff    <= page_free ? run_inc[CW-1:0] : '0;
            if (hit) begin
               // mark the run just found: pages hit_lo up to the new cursor
               lo_ff      <= hit_lo;
               hi_ff      <= cursor_nx;
               set_ff     <= 1'b1;
               wa_ff      <= hit_lo[BL+WAW-1:BL];
               granted_ff <= 1'b1;
               first_ff   <= hit_lo[bpa_pkg::START_W-1:0];
            end
         end
         if (cmd.fail) begin
            cursor_ff  <= old_ff;
            granted_ff <= 1'b0;
            first_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_granted_ff <= granted_ff;
         rsp_first_ff   <= first_ff;
      end
   end

   assign rsp_granted = rsp_granted_ff;
   assign rsp_first   = rsp_first_ff;

endmodule

### hdl/bpa_ctrl.sv
// Controller of the page allocator: sequences clearing, scan passes, run marking
// and the result handshake. Talks to bpa_dpath through bpa_pkg command and status types.
module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  bpa_pkg::sts_type sts,
   output bpa_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_SCAN_RD, ST_SCAN, ST_RMW_RD, ST_RMW_WR, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      pass2_in      = pass2_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               pass2_in   = 1'b0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.op_free) begin
               state_in = sts.range_empty ? ST_RESP : ST_RMW_RD;
            end else begin
               state_in = sts.count_zero ? ST_RESP : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD, ST_SCAN: begin
            if (sts.scan_done) begin
               // pass exhausted: wrap once to page 0, then give up
               if (!pass2_ff) begin
                  cmd.pass2 = 1'b1;
                  pass2_in  = 1'b1;
                  state_in  = ST_SCAN_RD;
               end else begin
                  cmd.fail = 1'b1;
                  state_in = ST_RESP;
               end
            end else if (state_ff == ST_SCAN_RD) begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               cmd.scan_step = 1'b1;
               if (sts.hit) begin
                  state_in = ST_RMW_RD;
               end else if (sts.boundary) begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_RMW_RD: begin
            cmd.rmw_rd = 1'b1;
            state_in   = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            cmd.rmw_wr = 1'b1;
            state_in   = sts.rmw_last ? ST_RESP : ST_RMW_RD;
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.rsp_load  = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         pass2_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass2_ff      <= pass2_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

### hdl/bitmap_page_allocator_next_fit.sv
// Next-fit bitmap page allocator. After reset the block sweeps the bitmap to all-used,
// one word per cycle, and takes no transaction until that is done. An allocate scans
// one page per cycle from the cursor, pausing to fetch each bitmap word it enters,
// because every word is fetched through the single memory read port; a found run is
// then marked by reading and writing back each word it touches. A free reads and
// writes back each word in its range. A zero count or an empty free range answers
// without touching the bitmap. WORD_BITS must be a power of two.
module bitmap_page_allocator_next_fit #(
   parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
   parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data,     // page_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,    // [15:0] start_page, [32:16] page_count, rest zero
   input  logic        req_tuser,    // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [15:0] first_page
   output logic        rsp_tuser     // granted
);

   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bpa_dpath #(
      .MAX_PAGES (MAX_PAGES),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr      (csr_valid && csr_ready),
      .csr_value   (csr_data),
      .req_op      (req_tuser),
      .req_start   (req_tdata[15:0]),
      .req_count   (req_tdata[32:16]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_granted (rsp_tuser),
      .rsp_first   (rsp_tdata)
   );

   // one transaction at a time: busy right after taking one
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // a refused allocation carries page 0
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 16'd0))
      else $error("failed allocation with nonzero page");

   // the result register loads only when the slot is free or being drained
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before transfer");

endmodule

### dv/bpa_alloc_checker.sv
// Checker for the next-fit bitmap page allocator: watches the register, request and
// response channels, predicts each response and compares. Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [16:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending,
   output int          rsp_seen,
   output int          grant_seen
);

   localparam int PAGES = bpa_pkg::MAX_PAGES_DEF;

   typedef struct {
      bit          granted;
      logic [15:0] first_page;
   } alloc_answer_type;

   bit               page_busy [PAGES];
   int unsigned      cursor;
   int unsigned      page_limit;
   alloc_answer_type answer_q [$];

   // one pass from the cursor up to stop_at; the cursor moves past every page read
   function automatic bit find_run(input int unsigned stop_at, input int unsigned want,
                                   output int unsigned first);
      int unsigned run_len;
      int unsigned p;
      run_len = 0;
      first = 0;
      while (cursor < stop_at) begin
         p = cursor;
         cursor++;
         if (!page_busy[p]) begin
            run_len++;
            if (run_len == want) begin
               first = cursor - want;
               for (int unsigned i = first; i < cursor; i++) page_busy[i] = 1'b1;
               return 1'b1;
            end
         end else begin
            run_len = 0;
         end
      end
      return 1'b0;
   endfunction

   function automatic alloc_answer_type predict_request(input logic op,
                                                        input int unsigned start,
                                                        input int unsigned count);
      alloc_answer_type ans;
      int unsigned      stop_at;
      int unsigned      old_cursor;
      int unsigned      first;
      bit               ok;
      ans.granted = 1'b0;
      ans.first_page = '0;
      first = 0;
      if (op == bpa_pkg::OP_FREE) begin
         stop_at = start + count;
         if (stop_at > PAGES) stop_at = PAGES;
         for (int unsigned i = start; i < stop_at; i++) page_busy[i] = 1'b0;
         ans.granted = 1'b1;
      end else if (count != 0) begin
         stop_at = (page_limit > PAGES) ? PAGES : page_limit;
         old_cursor = cursor;
         ok = find_run(stop_at, count, first);
         if (!ok) begin
            // wrap the cursor and retry up to where it stood
            cursor = 0;
            ok = find_run(old_cursor, count, first);
            if (!ok) cursor = old_cursor;
         end
         ans.granted = ok;
         ans.first_page = ok ? first[15:0] : 16'd0;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      alloc_answer_type want;
      if (reset) begin
         foreach (page_busy[i]) page_busy[i] = 1'b1;
         cursor = 0;
         page_limit = 0;
         answer_q.delete();
         pending = 0;
         fail_count = 0;
         rsp_seen = 0;
         grant_seen = 0;
      end else begin
         if (csr_valid && csr_ready) page_limit = 32'(csr_data);
         if (req_tvalid && req_tready)
            answer_q.push_back(predict_request(req_tuser, 32'(req_tdata[15:0]),
                                               32'(req_tdata[32:16])));
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (rsp_tuser) grant_seen++;
            if (answer_q.size() == 0) begin
               $error("unexpected response granted=%0d first_page=%0d",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.granted) begin
                  $error("granted: expected %0d, actual %0d", want.granted, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== want.first_page) begin
                  $error("first_page: expected %0d, actual %0d",
                         want.first_page, rsp_tdata);
                  fail_count++;
               end
            end
         end
         pending = answer_q.size();
      end
   end

endmodule

### dv/tb_bitmap_page_allocator_next_fit.sv
// Testbench top for bitmap_page_allocator_next_fit: drives registers and requests,
// stalls the response side, and reports the verdict. Depends on bpa_pkg and bpa_alloc_checker.
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_next_fit;

   localparam int QUIET_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   int fail_count, pending, rsp_seen, grant_seen;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int sent = 0;

   always #6 clock = ~clock;

   bitmap_page_allocator_next_fit u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   bpa_alloc_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen),
      .grant_seen(grant_seen)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: quiet cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
          (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("bitmap_page_allocator_next_fit regression: fail");
            $finish;
         end
      end
   end

   task automatic send(input logic op, input int unsigned start, input int unsigned count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, count[16:0], start[15:0]};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   // hold off until every response is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_limit(input int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value[16:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item(input int unsigned lim);
      int unsigned start, count;
      if ($urandom_range(99) < 45) begin
         start = $urandom_range(lim + 32);
         if (start > 65535) start = 65535;
         count = ($urandom_range(9) == 0) ? $urandom_range(lim) : $urandom_range(16);
         send(bpa_pkg::OP_FREE, start, count);
      end else begin
         case ($urandom_range(19))
            0:       count = 0;
            1, 2, 3: count = $urandom_range(lim / 2 + 1, 1);
            default: count = $urandom_range(8, 1);
         endcase
         send(bpa_pkg::OP_ALLOC, $urandom_range(65535), count);
      end
   endtask

   initial begin
      int unsigned limits [4] = '{64, 256, 512, 100};
      int          idle_set [4] = '{0, 83, 0, 18};
      int          stall_set [4] = '{0, 0, 83, 18};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero limit: allocations fail, including a zero count; an empty free is granted
      send(bpa_pkg::OP_ALLOC, 0, 1);
      send(bpa_pkg::OP_ALLOC, 0, 0);
      send(bpa_pkg::OP_FREE, 0, 0);
      // limit beyond the store
      write_limit(131071);
      send(bpa_pkg::OP_FREE, 0, 128);
      send(bpa_pkg::OP_ALLOC, 65535, 128);
      send(bpa_pkg::OP_ALLOC, 0, 0);
      send(bpa_pkg::OP_FREE, 0, 65536);
      send(bpa_pkg::OP_ALLOC, 0, 65536);
      send(bpa_pkg::OP_ALLOC, 0, 1);
      send(bpa_pkg::OP_FREE, 65535, 131071);
      send(bpa_pkg::OP_ALLOC, 0, 1);
      send(bpa_pkg::OP_FREE, 100, 50);
      send(bpa_pkg::OP_ALLOC, 0, 50);
      send(bpa_pkg::OP_FREE, 10, 20);
      send(bpa_pkg::OP_FREE, 60, 10);
      // cursor now above the limit: second pass covers pages past the limit
      write_limit(64);
      send(bpa_pkg::OP_ALLOC, 0, 10);
      send(bpa_pkg::OP_ALLOC, 0, 8);
      send(bpa_pkg::OP_ALLOC, 0, 100);
      send(bpa_pkg::OP_FREE, 65535, 1);
      write_limit(65536);
      send(bpa_pkg::OP_ALLOC, 0, 1);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_set[ph];
         recv_stall_pct = stall_set[ph];
         write_limit(limits[ph]);
         for (int n = 0; n < 430; n++) begin
            random_item(limits[ph]);
            if (n == 200) drain();
         end
      end

      drain();
      recv_stall_pct = 0;
      repeat (50) @(posedge clock);
      $display("covered %0d requests, %0d responses, %0d granted, limits 0 to 131071,",
               sent, rsp_seen, grant_seen);
      $display("with sender idling and receiver stalling in four mixes");
      if (fail_count == 0 && pending == 0) begin
         $display("bitmap_page_allocator_next_fit regression: pass");
      end else begin
         $display("bitmap_page_allocator_next_fit regression: fail");
      end
      $finish;
   end

endmodule
